// ----- hw/rtl/srs_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted range search package
// Shared widths, default sizes and the action codes of the request channel.
// ----------------------------------------------------------------------------
package srs_pkg;

   localparam int DATA_W        = 32;    // element and target width
   localparam int IDX_W         = 10;    // width of reported indices
   localparam int ACTION_W      = 2;
   localparam int DEPTH_DEFAULT = 1024;

   typedef enum logic [ACTION_W-1:0] {
      ACT_CLEAR  = 2'd0,
      ACT_APPEND = 2'd1,
      ACT_SEARCH = 2'd2
   } action_type;

endpackage

// ----- hw/rtl/srs_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted range search channels
// Valid/ready channels for requests and search responses.
// ----------------------------------------------------------------------------
interface srs_req_if;
   import srs_pkg::*;

   logic                       valid;
   logic                       ready;
   logic [ACTION_W-1:0]        action;
   logic signed [DATA_W-1:0]   element_value;
   logic signed [DATA_W-1:0]   search_target;

   modport source (output valid, output action, output element_value,
                   output search_target, input ready);
   modport sink   (input valid, input action, input element_value,
                   input search_target, output ready);
endinterface

interface srs_rsp_if;
   import srs_pkg::*;

   logic              valid;
   logic              ready;
   logic              found;
   logic [IDX_W-1:0]  first_index;
   logic [IDX_W-1:0]  last_index;

   modport source (output valid, output found, output first_index,
                   output last_index, input ready);
   modport sink   (input valid, input found, input first_index,
                   input last_index, output ready);
endinterface

// ----- hw/rtl/srs_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port; read data is registered.
// ----------------------------------------------------------------------------
module srs_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule

// ----- hw/rtl/sorted_range_search_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted range search
// Element store with append, clear and first/last-match binary search.
// ----------------------------------------------------------------------------
// The block keeps up to DEPTH signed 32-bit elements, expected in ascending
// order, in one synchronous RAM. A clear or append request completes as
// it is accepted and produces no response. A search request runs a plain
// binary search for any matching index; if one is found, a leftmost-match
// search over [0, hit] and a rightmost-match search over [hit, count-1]
// follow, and one response transfer carries found, first_index and
// last_index (both zero when nothing matches). Every probe issues the RAM
// read at the midpoint in ST_PROBE and compares the returned element in
// ST_COMPARE. Requests are taken one at a time. A finished response sits
// in an output register, so the next request is accepted while it waits
// to be taken. There is no clearing pass after reset; entries are read
// only after they were appended.
// ----------------------------------------------------------------------------
module sorted_range_search_top #(
   parameter int DEPTH = srs_pkg::DEPTH_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   srs_req_if.sink   req_if,
   srs_rsp_if.source rsp_if
);
   import srs_pkg::*;

   localparam int AW = $clog2(DEPTH);        // RAM address width
   localparam int CW = $clog2(DEPTH + 1);    // element count width
   localparam int SW = CW + 1;               // signed search bound width
   localparam int EW = (AW > IDX_W) ? AW : IDX_W;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PROBE,
      ST_COMPARE
   } state_type;

   // Which of the three binary searches is running.
   typedef enum logic [1:0] {
      PH_ANY,
      PH_FIRST,
      PH_LAST
   } phase_type;

   state_type                state_ff, state_in;
   phase_type                phase_ff, phase_in;
   logic [CW-1:0]            count_ff, count_in;
   logic signed [DATA_W-1:0] target_ff, target_in;
   logic signed [SW-1:0]     lo_ff, lo_in;
   logic signed [SW-1:0]     hi_ff, hi_in;
   logic [AW-1:0]            mid_ff, mid_in;
   logic [AW-1:0]            hit_ff, hit_in;
   logic [AW-1:0]            best_ff, best_in;
   logic [AW-1:0]            first_ff, first_in;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     found_ff, found_in;
   logic [IDX_W-1:0]         first_index_ff, first_index_in;
   logic [IDX_W-1:0]         last_index_ff, last_index_in;

   logic                     wr_en;
   logic [DATA_W-1:0]        rd_data;
   logic signed [DATA_W-1:0] rd_value;
   logic signed [SW-1:0]     span;
   logic signed [SW-1:0]     mid_wide;
   logic [AW-1:0]            mid_addr;
   logic signed [SW-1:0]     mid_ext;
   logic signed [SW-1:0]     hit_ext;
   logic signed [SW-1:0]     last_pos;
   logic                     out_free;
   logic [EW-1:0]            first_wide;
   logic [EW-1:0]            last_wide;

   // The element store. Writes happen only from idle, read data is used only
   // while a search probes, so the two ports never touch the same entry at once.
   srs_ram #(
      .WIDTH (DATA_W),
      .DEPTH (DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (count_ff[AW-1:0]),
      .wr_data (req_if.element_value),
      .rd_addr (mid_addr),
      .rd_data (rd_data)
   );

   // Midpoint of the live interval, rounded down. It is only used while
   // lo <= hi, when both bounds are non-negative and below the count.
   assign span     = hi_ff - lo_ff;
   assign mid_wide = lo_ff + (span >>> 1);
   assign mid_addr = mid_wide[AW-1:0];

   assign rd_value = signed'(rd_data);
   assign mid_ext  = signed'(SW'({1'b0, mid_ff}));
   assign hit_ext  = signed'(SW'({1'b0, hit_ff}));
   assign last_pos = signed'(SW'(count_ff)) - SW'(1);

   // The response register may be loaded when empty or being drained.
   assign out_free = !rsp_valid_ff || rsp_if.ready;

   // Reported indices keep their low ten bits.
   assign first_wide = EW'(first_ff);
   assign last_wide  = EW'(best_ff);

   assign req_if.ready       = (state_ff == ST_IDLE);
   assign rsp_if.valid       = rsp_valid_ff;
   assign rsp_if.found       = found_ff;
   assign rsp_if.first_index = first_index_ff;
   assign rsp_if.last_index  = last_index_ff;

   always_comb begin
      state_in       = state_ff;
      phase_in       = phase_ff;
      count_in       = count_ff;
      target_in      = target_ff;
      lo_in          = lo_ff;
      hi_in          = hi_ff;
      mid_in         = mid_ff;
      hit_in         = hit_ff;
      best_in        = best_ff;
      first_in       = first_ff;
      found_in       = found_ff;
      first_index_in = first_index_ff;
      last_index_in  = last_index_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_if.ready;
      wr_en          = 1'b0;

      case (state_ff)
         ST_IDLE: begin
            if (req_if.valid) begin
               case (action_type'(req_if.action))
                  ACT_CLEAR: begin
                     count_in = '0;
                  end
                  ACT_APPEND: begin
                     // An append to a full store is dropped.
                     if (count_ff < CW'(DEPTH)) begin
                        wr_en    = 1'b1;
                        count_in = count_ff + CW'(1);
                     end
                  end
                  ACT_SEARCH: begin
                     target_in = req_if.search_target;
                     lo_in     = '0;
                     hi_in     = last_pos;
                     phase_in  = PH_ANY;
                     state_in  = ST_PROBE;
                  end
                  default: begin
                  end
               endcase
            end
         end

         ST_PROBE: begin
            if (lo_ff > hi_ff) begin
               // The current search has run out of interval.
               case (phase_ff)
                  PH_ANY: begin
                     if (out_free) begin
                        rsp_valid_in   = 1'b1;
                        found_in       = 1'b0;
                        first_index_in = '0;
                        last_index_in  = '0;
                        state_in       = ST_IDLE;
                     end
                  end
                  PH_FIRST: begin
                     first_in = best_ff;
                     lo_in    = hit_ext;
                     hi_in    = last_pos;
                     best_in  = hit_ff;
                     phase_in = PH_LAST;
                  end
                  PH_LAST: begin
                     if (out_free) begin
                        rsp_valid_in   = 1'b1;
                        found_in       = 1'b1;
                        first_index_in = first_wide[IDX_W-1:0];
                        last_index_in  = last_wide[IDX_W-1:0];
                        state_in       = ST_IDLE;
                     end
                  end
                  default: begin
                     state_in = ST_IDLE;
                  end
               endcase
            end else begin
               // The RAM read at the midpoint is in flight.
               mid_in   = mid_addr;
               state_in = ST_COMPARE;
            end
         end

         ST_COMPARE: begin
            state_in = ST_PROBE;
            case (phase_ff)
               PH_ANY: begin
                  if (rd_value == target_ff) begin
                     // Any hit starts the leftmost search over [0, hit].
                     hit_in   = mid_ff;
                     best_in  = mid_ff;
                     lo_in    = '0;
                     hi_in    = mid_ext;
                     phase_in = PH_FIRST;
                  end else if (rd_value > target_ff) begin
                     hi_in = mid_ext - SW'(1);
                  end else begin
                     lo_in = mid_ext + SW'(1);
                  end
               end
               PH_FIRST: begin
                  if (rd_value >= target_ff) begin
                     hi_in = mid_ext - SW'(1);
                     if (rd_value == target_ff) begin
                        best_in = mid_ff;
                     end
                  end else begin
                     lo_in = mid_ext + SW'(1);
                  end
               end
               PH_LAST: begin
                  if (rd_value <= target_ff) begin
                     lo_in = mid_ext + SW'(1);
                     if (rd_value == target_ff) begin
                        best_in = mid_ff;
                     end
                  end else begin
                     hi_in = mid_ext - SW'(1);
                  end
               end
               default: begin
                  state_in = ST_IDLE;
               end
            endcase
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         phase_ff     <= PH_ANY;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         phase_ff     <= phase_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      target_ff      <= target_in;
      lo_ff          <= lo_in;
      hi_ff          <= hi_in;
      mid_ff         <= mid_in;
      hit_ff         <= hit_in;
      best_ff        <= best_in;
      first_ff       <= first_in;
      found_ff       <= found_in;
      first_index_ff <= first_index_in;
      last_index_ff  <= last_index_in;
   end

endmodule

// ----- dv/srs_result_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted range search result checker
// Watches the request and response channels, keeps its own copy of the
// element store and predicts the found/first/last answer of every search.
// ----------------------------------------------------------------------------
module srs_result_checker #(
   parameter int DEPTH = srs_pkg::DEPTH_DEFAULT
) (
   input  logic clock,
   input  logic reset,
   srs_req_if   req_mon,
   srs_rsp_if   rsp_mon,
   output int   fail_count,
   output int   pending_results
);
   import srs_pkg::*;

   typedef struct packed {
      logic             found;
      logic [IDX_W-1:0] first_index;
      logic [IDX_W-1:0] last_index;
   } match_range_type;

   logic signed [DATA_W-1:0] elements [DEPTH];
   int                       element_total = 0;
   match_range_type          expected_ranges [$];

   // Any-hit search first, then leftmost and rightmost bound searches that
   // both start from the hit as their best match.
   function automatic match_range_type predict_range(logic signed [DATA_W-1:0] target);
      int              lo;
      int              hi;
      int              mid;
      int              hit;
      int              first;
      int              last;
      match_range_type range;
      range = '0;
      hit   = -1;
      lo    = 0;
      hi    = element_total - 1;
      while (lo <= hi && hit < 0) begin
         mid = lo + (hi - lo) / 2;
         if (elements[mid] == target) hit = mid;
         else if (elements[mid] > target) hi = mid - 1;
         else lo = mid + 1;
      end
      if (hit >= 0) begin
         first = hit;
         lo    = 0;
         hi    = hit;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (elements[mid] >= target) begin
               hi = mid - 1;
               if (elements[mid] == target) first = mid;
            end else begin
               lo = mid + 1;
            end
         end
         last = hit;
         lo   = hit;
         hi   = element_total - 1;
         while (lo <= hi) begin
            mid = lo + (hi - lo) / 2;
            if (elements[mid] <= target) begin
               lo = mid + 1;
               if (elements[mid] == target) last = mid;
            end else begin
               hi = mid - 1;
            end
         end
         range.found       = 1'b1;
         range.first_index = first[IDX_W-1:0];
         range.last_index  = last[IDX_W-1:0];
      end
      return range;
   endfunction

   function automatic void check_field(string field, logic [31:0] want, logic [31:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
         fail_count++;
      end
   endfunction

   always @(posedge clock) begin
      match_range_type want;
      if (reset) begin
         fail_count    = 0;
         element_total = 0;
         expected_ranges.delete();
      end else begin
         // A response can only belong to a search taken at an earlier edge,
         // so it is compared before this edge's request is applied.
         if (rsp_mon.valid && rsp_mon.ready) begin
            if (expected_ranges.size() == 0) begin
               $display("%0t: unexpected response, expected none, %s=%0d first=%0d last=%0d",
                        $time, "actual found", rsp_mon.found, rsp_mon.first_index,
                        rsp_mon.last_index);
               fail_count++;
            end else begin
               want = expected_ranges.pop_front();
               check_field("found", 32'(want.found), 32'(rsp_mon.found));
               check_field("first_index", 32'(want.first_index), 32'(rsp_mon.first_index));
               check_field("last_index", 32'(want.last_index), 32'(rsp_mon.last_index));
            end
         end
         if (req_mon.valid && req_mon.ready) begin
            case (req_mon.action)
               ACT_CLEAR: begin
                  element_total = 0;
               end
               ACT_APPEND: begin
                  if (element_total < DEPTH) begin
                     elements[element_total] = req_mon.element_value;
                     element_total++;
                  end
               end
               ACT_SEARCH: begin
                  expected_ranges.push_back(predict_range(req_mon.search_target));
               end
               default: begin
               end
            endcase
         end
      end
      pending_results <= expected_ranges.size();
   end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Sorted range search testbench
// Drives clear, append and search requests into the block under random flow
// control and lets the result checker compare every search response.
// ----------------------------------------------------------------------------
module testbench;
   import srs_pkg::*;

   localparam int DEPTH          = DEPTH_DEFAULT;
   localparam int RANDOM_ITEMS   = 600;
   localparam int HOLD_CYCLES    = 400;
   localparam int SETTLE_CYCLES  = 150;
   localparam int WATCHDOG_LIMIT = 5000;

   // The one action code that the package leaves unnamed; the block must
   // ignore it entirely.
   localparam logic [ACTION_W-1:0]  ACT_UNUSED = 2'd3;
   localparam logic signed [DATA_W-1:0] VAL_MIN = {1'b1, {(DATA_W-1){1'b0}}};
   localparam logic signed [DATA_W-1:0] VAL_MAX = {1'b0, {(DATA_W-1){1'b1}}};

   logic clock = 1'b0;
   logic reset;

   srs_req_if req_ch ();
   srs_rsp_if rsp_ch ();

   int fail_count;
   int pending_results;

   sorted_range_search_top #(.DEPTH(DEPTH)) uut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   srs_result_checker #(.DEPTH(DEPTH)) checker_inst (
      .clock           (clock),
      .reset           (reset),
      .req_mon         (req_ch),
      .rsp_mon         (rsp_ch),
      .fail_count      (fail_count),
      .pending_results (pending_results)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Flow control knobs. The sender's idle share is only used by the
   // stimulus process; the receiver's knobs are handed over with
   // nonblocking assignments so that the receiver sees them at a clean edge.
   int send_idle_pct  = 0;
   int recv_stall_pct = 0;
   bit hold_phase     = 1'b0;
   bit hold_seen      = 1'b0;
   int hold_left      = 0;
   int items_sent     = 0;
   int idle_cycles    = 0;

   // Host-side copy of the elements appended since the last clear. Search
   // targets are mostly drawn from it so that most searches hit.
   logic signed [DATA_W-1:0] stored [$];

   // Receiver. A rising edge on hold_phase starts a long hold-off that is
   // counted here, so that the block fills up and stops taking requests;
   // otherwise ready is dropped at random according to the stall share.
   always @(posedge clock) begin
      hold_seen <= hold_phase;
      if (reset) begin
         hold_left    <= 0;
         rsp_ch.ready <= 1'b0;
      end else if (hold_phase && !hold_seen) begin
         hold_left    <= HOLD_CYCLES;
         rsp_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
         hold_left    <= hold_left - 1;
         rsp_ch.ready <= 1'b0;
      end else begin
         rsp_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
      end
   end

   // Watchdog: a run in which nothing moves on either channel for too long
   // is declared dead.
   always @(posedge clock) begin
      if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles == WATCHDOG_LIMIT) begin
         $display("** sorted_range_search_top: FAILED **");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // Offer one request and hold it until the transfer happens. A random gap
   // may come first; when there is none, valid simply stays high so that it
   // gets exactly one assignment in this time step.
   task automatic send_item(input logic [ACTION_W-1:0]  act,
                            input logic signed [DATA_W-1:0] elem,
                            input logic signed [DATA_W-1:0] tgt);
      if ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
         while ($urandom_range(99) < send_idle_pct) @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.action        <= act;
      req_ch.element_value <= elem;
      req_ch.search_target <= tgt;
      @(posedge clock);
      while (req_ch.ready !== 1'b1) @(posedge clock);
      items_sent++;
   endtask

   // Stop offering and wait until the checker has seen every response.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      @(posedge clock);
      while (pending_results != 0) @(posedge clock);
   endtask

   // Append a run of elements. Sorted runs continue from the last stored
   // element with steps that are often zero, which makes duplicate groups,
   // and they saturate at the largest value instead of wrapping.
   task automatic append_run(input int count, input bit scrambled);
      longint                   cur;
      int                       r;
      logic signed [DATA_W-1:0] next_val;
      for (int i = 0; i < count; i++) begin
         if (scrambled) begin
            next_val = $urandom;
         end else begin
            if (stored.size() == 0) begin
               r = $urandom_range(3);
               if (r == 0) cur = longint'(VAL_MIN);
               else if (r == 1) cur = longint'($urandom_range(200)) - 100;
               else cur = longint'($signed($urandom));
            end else begin
               r = $urandom_range(99);
               cur = longint'(stored[$]);
               if (r < 30) cur = cur;
               else if (r < 65) cur = cur + $urandom_range(1, 3);
               else if (r < 90) cur = cur + $urandom_range(1, 1 << 16);
               else cur = cur + $urandom_range(1, 1 << 22);
            end
            if (cur > longint'(VAL_MAX)) cur = longint'(VAL_MAX);
            next_val = cur[DATA_W-1:0];
         end
         stored.push_back(next_val);
         send_item(ACT_APPEND, next_val, $urandom);
      end
   endtask

   // Mostly a stored element, sometimes a neighbor of one (which usually
   // misses), a field extreme, or anything at all.
   function automatic logic signed [DATA_W-1:0] pick_target();
      int r;
      logic signed [DATA_W-1:0] pick;
      r = $urandom_range(99);
      if (stored.size() == 0 || r < 15) return $urandom;
      if (r < 25) return ($urandom_range(1) != 0) ? VAL_MAX : VAL_MIN;
      pick = stored[$urandom_range(stored.size() - 1)];
      if (r < 40) return ($urandom_range(1) != 0) ? pick + 1 : pick - 1;
      return pick;
   endfunction

   // One random sequence. Most are well formed: clear, a run of appends,
   // a few searches, and sometimes more appends and searches on top. A
   // few are unsorted, a few are pure noise over every action code, and a
   // rare one is larger so that indices well above the low bits show up.
   task automatic run_sequence();
      int kind;
      int count;
      kind = $urandom_range(99);
      if (kind < 6) begin
         repeat ($urandom_range(1, 4))
            send_item(ACTION_W'($urandom_range(int'(ACT_UNUSED))), $urandom, $urandom);
      end else begin
         send_item(ACT_CLEAR, $urandom, $urandom);
         stored.delete();
         count = ($urandom_range(99) < 4) ? $urandom_range(64, 256)
                                          : $urandom_range(0, 20);
         append_run(count, kind < 16);
         repeat ($urandom_range(1, 8)) send_item(ACT_SEARCH, $urandom, pick_target());
         if ($urandom_range(99) < 25) begin
            append_run($urandom_range(1, 4), 1'b0);
            repeat ($urandom_range(1, 3)) send_item(ACT_SEARCH, $urandom, pick_target());
         end
      end
   endtask

   initial begin
      int target_items;

      reset                <= 1'b1;
      req_ch.valid         <= 1'b0;
      req_ch.action        <= ACT_CLEAR;
      req_ch.element_value <= '0;
      req_ch.search_target <= '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // Directed part, no idling. A search right after reset sees an empty
      // store. Then a sorted store with duplicate groups at both field
      // extremes and in the middle, hits and misses on it, an unused action
      // code that must leave the store alone, a clear followed by a search
      // on the empty store, and finally an unsorted store.
      send_item(ACT_SEARCH, '0, '0);
      send_item(ACT_APPEND, VAL_MIN, '0);
      send_item(ACT_APPEND, VAL_MIN, '0);
      send_item(ACT_APPEND, -32'sd5, '0);
      send_item(ACT_APPEND, 32'sd0, '0);
      send_item(ACT_APPEND, 32'sd0, '0);
      send_item(ACT_APPEND, 32'sd0, '0);
      send_item(ACT_APPEND, 32'sd7, '0);
      send_item(ACT_APPEND, VAL_MAX, '0);
      send_item(ACT_APPEND, VAL_MAX, '0);
      send_item(ACT_SEARCH, '0, VAL_MIN);
      send_item(ACT_SEARCH, '0, 32'sd0);
      send_item(ACT_SEARCH, '0, 32'sd7);
      send_item(ACT_SEARCH, '0, VAL_MAX);
      send_item(ACT_SEARCH, '0, 32'sd1);
      send_item(ACT_SEARCH, '0, -32'sd6);
      send_item(ACT_UNUSED, VAL_MAX, VAL_MIN);
      send_item(ACT_SEARCH, '0, 32'sd0);
      send_item(ACT_CLEAR, '0, '0);
      send_item(ACT_SEARCH, '0, 32'sd0);
      send_item(ACT_APPEND, 32'sd5, '0);
      send_item(ACT_APPEND, 32'sd1, '0);
      send_item(ACT_APPEND, 32'sd9, '0);
      send_item(ACT_APPEND, 32'sd5, '0);
      send_item(ACT_SEARCH, '0, 32'sd5);
      send_item(ACT_SEARCH, '0, 32'sd1);
      send_item(ACT_SEARCH, '0, 32'sd9);
      wait_drained();

      // Back pressure: the receiver holds off for a long stretch while the
      // sender keeps offering searches, so the output register fills and the
      // request channel stalls. Afterwards the sender waits for every
      // response before it moves on.
      hold_phase <= 1'b1;
      send_item(ACT_CLEAR, '0, '0);
      stored.delete();
      append_run(12, 1'b0);
      repeat (10) send_item(ACT_SEARCH, $urandom, pick_target());
      hold_phase <= 1'b0;
      wait_drained();

      // Random part in four flow-control phases: no idling, an idle sender,
      // a stalling receiver, and both at once.
      items_sent = 0;
      for (int phase = 0; phase < 4; phase++) begin
         case (phase)
            0: begin
               send_idle_pct   = 0;
               recv_stall_pct <= 0;
            end
            1: begin
               send_idle_pct   = 51;
               recv_stall_pct <= 0;
            end
            2: begin
               send_idle_pct   = 0;
               recv_stall_pct <= 51;
            end
            default: begin
               send_idle_pct   = 27;
               recv_stall_pct <= 27;
            end
         endcase
         target_items = (phase + 1) * RANDOM_ITEMS / 4;
         while (items_sent < target_items) run_sequence();
         wait_drained();
      end

      // Give the block time to show any stray response.
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (fail_count == 0) begin
         $display("** sorted_range_search_top: PASSED **");
      end else begin
         $display("** sorted_range_search_top: FAILED **");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
hw/rtl/srs_pkg.sv
hw/rtl/srs_if.sv
hw/rtl/srs_ram.sv
hw/rtl/sorted_range_search_top.sv
dv/srs_result_checker.sv
dv/testbench.sv
